// ===== hw/rtl/gdda_los_pkg.sv =====
// shared types and constants for the grid line-of-sight unit
`default_nettype none

package gdda_los_pkg;

  localparam int COORD_W = 14;
  localparam int TILE_W  = 6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MUL_X,
    ST_MUL_Y,
    ST_BOUND,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grid_dda_line_of_sight_unit.sv =====
// grid line-of-sight unit: wall bitmap with a sequenced dda walk over one shared multiplier
// tile write: taken in idle, no result beat
// cast: accept, then per cell crossed the end-cell check, bound test and read on an axis-only walk and
//   check, mul_x, mul_y, bound and read otherwise, then done hands over the result; one cast at a time
// per cell off the axes the shared multiplier is used twice for the cross-multiplied compare, and per cell
//   the single map read port is used at most once
// reset (synchronous): clearing pass over every map cell, requests stalled
`default_nettype none

module grid_dda_line_of_sight_unit #(
  parameter int MAP_SIDE  = 64,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output      logic                              req_stall,
  input  wire logic                              kind,
  input  wire logic [gdda_los_pkg::TILE_W-1:0]   tile_col,
  input  wire logic [gdda_los_pkg::TILE_W-1:0]   tile_row,
  input  wire logic                              tile_is_wall,
  input  wire logic [gdda_los_pkg::COORD_W-1:0]  start_x,
  input  wire logic [gdda_los_pkg::COORD_W-1:0]  start_y,
  input  wire logic [gdda_los_pkg::COORD_W-1:0]  end_x,
  input  wire logic [gdda_los_pkg::COORD_W-1:0]  end_y,
  output      logic                              res_valid,
  input  wire logic                              res_stall,
  output      logic                              blocked,
  output      logic                              out_of_map
);

  localparam int CW     = gdda_los_pkg::COORD_W;
  localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int XI_W   = $clog2(MAP_SIDE);
  localparam int CELL_W = CW + 2;
  localparam int SA_W   = CW + 3;
  localparam int PROD_W = SA_W + CW;
  localparam logic [SA_W-1:0]   ONE_CELL  = SA_W'(1) << FRAC_BITS;
  localparam logic [SA_W-1:0]   FRAC_MASK = ONE_CELL - SA_W'(1);
  localparam logic [CELL_W-1:0] SIDE_C    = CELL_W'(MAP_SIDE);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

  gdda_los_pkg::state_t state, state_next;

  logic [AW-1:0]     clr_addr;
  logic [CELL_W-1:0] cell_x, cell_y, end_cx, end_cy;
  logic [CW-1:0]     adx, ady;
  logic              neg_x, neg_y;
  logic [SA_W-1:0]   side_x, side_y;
  logic [PROD_W-1:0] prod_a;
  logic              res_blocked, res_oom;

  logic              mem [DEPTH];
  logic              rd_data;

  logic              req_acc, at_end, in_map, tile_in_map;
  logic [AW-1:0]     rd_addr, wr_tile_addr;
  logic [SA_W-1:0]   fx, fy;

  // sequencer outputs
  logic              mem_we, mem_wd, rd_en, step_en, take_x, out_load;
  logic [AW-1:0]     mem_wa;
  logic [SA_W-1:0]   mul_a;
  logic [CW-1:0]     mul_b;
  logic [PROD_W-1:0] prod;

  assign req_acc     = req_valid && !req_stall;
  assign at_end      = (cell_x == end_cx) && (cell_y == end_cy);
  assign in_map      = (cell_x < SIDE_C) && (cell_y < SIDE_C);
  assign tile_in_map = (CELL_W'(tile_col) < SIDE_C) && (CELL_W'(tile_row) < SIDE_C);
  assign rd_addr     = AW'(cell_x[XI_W-1:0]) * AW'(MAP_SIDE) + AW'(cell_y[XI_W-1:0]);
  assign wr_tile_addr = AW'(tile_col) * AW'(MAP_SIDE) + AW'(tile_row);
  assign fx          = SA_W'(start_x) & FRAC_MASK;
  assign fy          = SA_W'(start_y) & FRAC_MASK;

  // the one multiplier, shared by both halves of the side compare
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_next = state;
    case (state)
      gdda_los_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = gdda_los_pkg::ST_IDLE;
      end
      gdda_los_pkg::ST_IDLE: begin
        if (req_valid && kind) state_next = gdda_los_pkg::ST_CHECK;
      end
      gdda_los_pkg::ST_CHECK: begin
        if (at_end) state_next = gdda_los_pkg::ST_DONE;
        else if (adx == '0 || ady == '0) state_next = gdda_los_pkg::ST_BOUND;
        else state_next = gdda_los_pkg::ST_MUL_X;
      end
      gdda_los_pkg::ST_MUL_X: state_next = gdda_los_pkg::ST_MUL_Y;
      gdda_los_pkg::ST_MUL_Y: state_next = gdda_los_pkg::ST_BOUND;
      gdda_los_pkg::ST_BOUND: begin
        state_next = in_map ? gdda_los_pkg::ST_READ : gdda_los_pkg::ST_DONE;
      end
      gdda_los_pkg::ST_READ: begin
        state_next = rd_data ? gdda_los_pkg::ST_DONE : gdda_los_pkg::ST_CHECK;
      end
      gdda_los_pkg::ST_DONE: begin
        if (!res_valid || !res_stall) state_next = gdda_los_pkg::ST_IDLE;
      end
      default: state_next = gdda_los_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    mem_we    = 1'b0;
    mem_wa    = clr_addr;
    mem_wd    = 1'b0;
    rd_en     = 1'b0;
    step_en   = 1'b0;
    take_x    = 1'b0;
    out_load  = 1'b0;
    mul_a     = side_y;
    mul_b     = adx;
    case (state)
      gdda_los_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      gdda_los_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid && !kind && tile_in_map) begin
          mem_we = 1'b1;
          mem_wa = wr_tile_addr;
          mem_wd = tile_is_wall;
        end
      end
      gdda_los_pkg::ST_CHECK: begin
        // a zero component never steps; only one of them zero decides the axis at once
        if (!at_end && (adx == '0 || ady == '0)) begin
          step_en = 1'b1;
          take_x  = (adx != '0);
        end
      end
      gdda_los_pkg::ST_MUL_X: begin
        mul_a = side_x;
        mul_b = ady;
      end
      gdda_los_pkg::ST_MUL_Y: begin
        // ties step y
        step_en = 1'b1;
        take_x  = prod_a < prod;
      end
      gdda_los_pkg::ST_BOUND: begin
        rd_en = in_map;
      end
      gdda_los_pkg::ST_READ: begin
      end
      gdda_los_pkg::ST_DONE: begin
        out_load = !res_valid || !res_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gdda_los_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == gdda_los_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req_acc && kind) begin
      cell_x <= CELL_W'(start_x) >> FRAC_BITS;
      cell_y <= CELL_W'(start_y) >> FRAC_BITS;
      end_cx <= CELL_W'(end_x) >> FRAC_BITS;
      end_cy <= CELL_W'(end_y) >> FRAC_BITS;
      neg_x  <= end_x < start_x;
      neg_y  <= end_y < start_y;
      adx    <= (end_x < start_x) ? start_x - end_x : end_x - start_x;
      ady    <= (end_y < start_y) ? start_y - end_y : end_y - start_y;
      // side distances from the start cell's boundary
      side_x <= (end_x < start_x) ? fx : ONE_CELL - fx;
      side_y <= (end_y < start_y) ? fy : ONE_CELL - fy;
    end
    if (state == gdda_los_pkg::ST_MUL_X) prod_a <= prod;
    if (step_en) begin
      if (take_x) begin
        cell_x <= neg_x ? cell_x - CELL_W'(1) : cell_x + CELL_W'(1);
        side_x <= side_x + ONE_CELL;
      end else begin
        cell_y <= neg_y ? cell_y - CELL_W'(1) : cell_y + CELL_W'(1);
        side_y <= side_y + ONE_CELL;
      end
    end
    if (state == gdda_los_pkg::ST_CHECK && at_end) begin
      res_blocked <= 1'b0;
      res_oom     <= 1'b0;
    end
    // a step below zero wraps to a large cell and fails the bound test
    if (state == gdda_los_pkg::ST_BOUND && !in_map) begin
      res_blocked <= 1'b1;
      res_oom     <= 1'b1;
    end
    if (state == gdda_los_pkg::ST_READ && rd_data) begin
      res_blocked <= 1'b1;
      res_oom     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      blocked    <= res_blocked;
      out_of_map <= res_oom;
    end
  end

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == gdda_los_pkg::ST_DONE)
    else $error("result beat raised outside the hand-over state");

  a_clear_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid && !blocked |-> !out_of_map)
    else $error("clear result flagged as off the map");

  a_read_after_bound: assert property (@(posedge clk) disable iff (rst)
    state == gdda_los_pkg::ST_READ |-> $past(state) == gdda_los_pkg::ST_BOUND && $past(in_map))
    else $error("map read without an in-map bound test");

  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    state == gdda_los_pkg::ST_MUL_Y |-> $past(state) == gdda_los_pkg::ST_MUL_X)
    else $error("second compare half without the first");

endmodule

`default_nettype wire
